### sv/tws_pkg.sv
// Shared types and constants for the three-week calendar strip.
// Used by tws_prep, tws_emit and three_week_calendar_strip; no dependencies.
`default_nettype none

package tws_pkg;

   // Strip geometry
   localparam int unsigned StripCells = 21;
   localparam logic [4:0]  LastCell   = 5'd20;
   localparam logic [4:0]  WeekLen    = 5'd7;

   // Month codes that need a length other than 31 days
   localparam logic [3:0] MonthFeb = 4'd1;
   localparam logic [3:0] MonthApr = 4'd3;
   localparam logic [3:0] MonthJun = 4'd5;
   localparam logic [3:0] MonthSep = 4'd8;
   localparam logic [3:0] MonthNov = 4'd10;

   // Divisibility by 25: multiply by the inverse of 25 modulo 2^14, and
   // the product is at most 16383 / 25 exactly for the multiples of 25
   localparam logic [13:0] Inv25    = 14'd7209;
   localparam logic [13:0] Div25Max = 14'd655;

   // One input item
   typedef struct packed {
      logic [3:0]  month;
      logic [13:0] year;
      logic [2:0]  weekday;
      logic [4:0]  day_of_month;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic [4:0] day_number;
      logic [4:0] cell_index;
      logic       is_today;
      logic       last_cell;
   } rsp_item_type;

   // Per-date layout handed from the prep stage to the cell emitter
   typedef struct packed {
      logic [3:0] prior;      // cell of the input date
      logic [3:0] vis;        // cells taken by the previous month
      logic [4:0] first_day;  // value of cell 0
      logic [4:0] this_len;   // length of this month
      logic [4:0] prev_len;   // length of the previous month
   } plan_type;

endpackage

`default_nettype wire

### sv/tws_prep.sv
// Input stage of the calendar strip: week start register, leap and month
// length logic, and the plan register that holds one date's layout.
// Depends on tws_pkg.
`default_nettype none

module tws_prep (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tws_pkg::req_item_type req_data,
   output logic                       plan_valid,
   output tws_pkg::plan_type          plan,
   input  wire logic                  plan_take
);
   import tws_pkg::*;

   logic [2:0]  week_start_ff;
   logic [2:0]  week_start_in;
   logic        plan_valid_ff;
   logic        plan_valid_in;
   plan_type    plan_ff;
   plan_type    plan_in;
   logic        accept;

   logic [27:0] year_prod;
   logic        div25;
   logic        leap;
   logic [3:0]  prev_month;
   logic [4:0]  prior5;
   logic [4:0]  vis5;
   logic [4:0]  this_len;
   logic [4:0]  prev_len;

   // Length of a month; codes above December count as 31 days
   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic is_leap);
      logic [4:0] len;
      case (mon)
         MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
         MonthFeb: len = is_leap ? 5'd29 : 5'd28;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Latch the week start on a write
   assign week_start_in = csr_wr_en ? csr_wr_data : week_start_ff;

   // Gregorian rule: by 4, and not by 100 unless by 400
   assign year_prod = req_data.year * Inv25;
   assign div25     = year_prod[13:0] <= Div25Max;
   assign leap      = (req_data.year[1:0] == 2'b00) &&
                      (!div25 || (req_data.year[3:0] == 4'b0000));

   // January wraps to code 15, which reads as 31 days like the model's rule
   assign prev_month = req_data.month - 4'd1;
   assign this_len   = month_len(req_data.month, leap);
   assign prev_len   = month_len(prev_month, leap);

   // Cell of the input date and the layout of the strip's start
   always_comb begin
      prior5 = {2'b00, req_data.weekday} + WeekLen - {2'b00, week_start_ff};
      if (req_data.weekday < week_start_ff) begin
         prior5 = prior5 + WeekLen;
      end
      plan_in.prior    = prior5[3:0];
      plan_in.this_len = this_len;
      plan_in.prev_len = prev_len;
      if (prior5 >= req_data.day_of_month) begin
         vis5              = prior5 - req_data.day_of_month + 5'd1;
         plan_in.vis       = vis5[3:0];
         plan_in.first_day = prev_len + 5'd1 - vis5;
      end else begin
         vis5              = 5'd0;
         plan_in.vis       = 4'd0;
         plan_in.first_day = req_data.day_of_month - prior5;
      end
   end

   // Take a new item when the plan slot is free or drains this cycle
   assign req_stall     = plan_valid_ff && !plan_take;
   assign accept        = req_valid && !req_stall;
   assign plan_valid_in = accept ? 1'b1 : (plan_take ? 1'b0 : plan_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         week_start_ff <= 3'd0;
         plan_valid_ff <= 1'b0;
      end else begin
         week_start_ff <= week_start_in;
         plan_valid_ff <= plan_valid_in;
      end
   end

   // Hold the plan payload until the emitter loads it
   always_ff @(posedge clock) begin
      if (accept) begin
         plan_ff <= plan_in;
      end
   end

   assign plan_valid = plan_valid_ff;
   assign plan       = plan_ff;

endmodule

`default_nettype wire

### sv/tws_emit.sv
// Cell emitter of the calendar strip: walks one plan through 21 cells and
// drives the result register.
// Depends on tws_pkg.
`default_nettype none

module tws_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              plan_valid,
   input  wire tws_pkg::plan_type plan,
   output logic                   plan_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tws_pkg::rsp_item_type  rsp_data
);
   import tws_pkg::*;

   logic         active_ff;
   logic         active_in;
   logic [4:0]   cell_ff;
   logic [4:0]   cell_in;
   logic [4:0]   day_ff;
   logic [4:0]   day_in;
   plan_type     cur_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_item_type rsp_ff;
   rsp_item_type rsp_in;

   logic         out_free;
   logic         emit;
   logic         is_last;
   logic         in_prev;
   logic [4:0]   limit;
   logic [4:0]   next_day;

   // While active, emit one cell whenever the result register is free or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = active_ff && out_free;
   assign is_last  = cell_ff == LastCell;

   // Load the next plan when idle or as the final cell is emitted
   assign plan_take = plan_valid && (!active_ff || (emit && is_last));

   // Count up, wrapping past the end of whichever month the cell is in
   assign in_prev  = cell_ff < {1'b0, cur_ff.vis};
   assign limit    = in_prev ? cur_ff.prev_len : cur_ff.this_len;
   assign next_day = (day_ff >= limit) ? 5'd1 : day_ff + 5'd1;

   always_comb begin
      active_in = active_ff;
      cell_in   = cell_ff;
      day_in    = day_ff;
      if (plan_take) begin
         active_in = 1'b1;
         cell_in   = 5'd0;
         day_in    = plan.first_day;
      end else if (emit) begin
         active_in = !is_last;
         cell_in   = cell_ff + 5'd1;
         day_in    = next_day;
      end
   end

   // Build the result item for the current cell
   always_comb begin
      rsp_in.day_number = day_ff;
      rsp_in.cell_index = cell_ff;
      rsp_in.is_today   = cell_ff == {1'b0, cur_ff.prior};
      rsp_in.last_cell  = is_last;
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk state and payload registers
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      day_ff  <= day_in;
      if (plan_take) begin
         cur_ff <= plan;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A plan is loaded only when one is waiting
   a_take_needs_plan: assert property (@(posedge clock) disable iff (reset)
      plan_take |-> plan_valid)
      else $error("emitter loaded a plan that was not valid");

   // Every emitted cell carries a day number of at least one
   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      emit |-> (day_ff != 5'd0))
      else $error("emitted a cell with day number zero");

   // After the final cell with nothing queued the emitter goes idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit && is_last && !plan_valid) |=> !active_ff)
      else $error("emitter stayed active past the final cell");

   // A fresh item starts at cell zero
   a_start_at_zero: assert property (@(posedge clock) disable iff (reset)
      plan_take |=> (active_ff && (cell_ff == 5'd0)))
      else $error("loaded item did not start at cell zero");

endmodule

`default_nettype wire

### sv/three_week_calendar_strip.sv
// Top level of the three-week calendar strip: csr register, prep stage
// and cell emitter. Depends on tws_pkg, tws_prep and tws_emit.
`default_nettype none

// Each accepted date yields 21 result items, cells 0 to 20 in order, one per
// cycle on the result channel while rsp_stall is low; a steady stream of dates
// is paced by the single result register, which carries one cell a cycle. The
// next date is taken into the plan register while the current one is still
// being emitted, so dates follow with no gap. From an idle block a date goes
// through the plan register and the emitter's walk registers into the result
// register. Write week_start_day only while no date is in flight.
module three_week_calendar_strip (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tws_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tws_pkg::rsp_item_type      rsp_data
);
   import tws_pkg::*;

   logic     plan_valid;
   plan_type plan;
   logic     plan_take;

   // Work out the layout of one date
   tws_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .plan_valid  (plan_valid),
      .plan        (plan),
      .plan_take   (plan_take)
   );

   // Emit the strip cells
   tws_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan_valid (plan_valid),
      .plan       (plan),
      .plan_take  (plan_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### verif/tws_checker.sv
// Scoreboard for the three-week calendar strip: watches the csr port and both
// channels, predicts the 21 cells of every accepted date and compares them.
// Depends on tws_pkg for the item types and strip constants.
`timescale 1ns / 1ps

module tws_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [2:0]            csr_wr_data,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire tws_pkg::req_item_type req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire tws_pkg::rsp_item_type rsp_data,
   output int unsigned                fail_count,
   output int unsigned                cells_owed
);
   import tws_pkg::*;

   logic [2:0]   week_start = '0;
   rsp_item_type strip_cells[$];
   rsp_item_type want;
   int unsigned  errs = 0;

   // Gregorian month length; months above December count as 31 days
   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      int unsigned leap;
      leap = ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 1 : 0;
      if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
         return 30;
      end
      if (m == MonthFeb) begin
         return 28 + leap;
      end
      return 31;
   endfunction

   // Queue the strip cells that one date must produce
   function automatic void predict_strip(req_item_type d);
      int unsigned wd, ws, dom, slot, this_len, prev_len, vis, day, val, c;
      rsp_item_type strip_item;
      wd  = d.weekday;
      ws  = week_start;
      dom = d.day_of_month;
      // place today in the middle row, also when it falls before the start of
      // the week; only weekday 7 with start day 0 reaches the last row
      slot = WeekLen + wd - ws;
      if (wd < ws) begin
         slot += WeekLen;
      end
      this_len = days_in_month(d.month, d.year);
      prev_len = 0;
      if (slot >= dom) begin
         // strip reaches back into the previous month; January looks back
         // at a 31-day December
         prev_len = (d.month == 0) ? 31 : days_in_month(d.month - 1, d.year);
         vis = slot - dom + 1;
         day = 1;
      end else begin
         vis = 0;
         day = dom - slot;
      end
      for (c = 0; c < StripCells; c++) begin
         if (c < vis) begin
            val = prev_len + c + 1 - vis;
         end else begin
            val = day;
            day++;
            if (day > this_len) begin
               day = 1;
            end
         end
         strip_item.day_number = val[4:0];
         strip_item.cell_index = c[4:0];
         strip_item.is_today   = (c == slot);
         strip_item.last_cell  = (c == LastCell);
         strip_cells.push_back(strip_item);
      end
   endfunction

   // Track the start day, check results against the oldest prediction,
   // then predict for any newly accepted date
   always @(posedge clock) begin
      if (reset) begin
         strip_cells.delete();
         week_start = '0;
      end else begin
         if (csr_wr_en) begin
            week_start = csr_wr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (strip_cells.size() == 0) begin
               errs++;
               $display("%0t: unexpected cell: expected none, got day %0d cell %0d",
                        $time, rsp_data.day_number, rsp_data.cell_index);
            end else begin
               want = strip_cells.pop_front();
               if (rsp_data !== want) begin
                  errs++;
                  // fields as day/cell/today/last
                  $display("%0t: cell mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                           $time, want.day_number, want.cell_index, want.is_today,
                           want.last_cell, rsp_data.day_number, rsp_data.cell_index,
                           rsp_data.is_today, rsp_data.last_cell);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_strip(req_data);
         end
      end
      fail_count <= errs;
      cells_owed <= strip_cells.size();
   end

endmodule

### verif/tb_top.sv
// Top of the calendar strip testbench: clock, reset, date stimulus, result
// back-pressure and the verdict. Depends on tws_pkg, tws_checker and the
// three_week_calendar_strip RTL.
`timescale 1ns / 1ps

module tb_top;
   import tws_pkg::*;

   localparam int unsigned PhaseCount  = 8;
   localparam int unsigned PhaseItems  = 50;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned LongHold    = 300;
   localparam int unsigned TimeLimitNs = 1800000;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [2:0]   csr_wr_data;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;
   int unsigned  fail_count;
   int unsigned  cells_owed;
   bit           calm         = 1'b0;
   bit           hold_results = 1'b0;

   three_week_calendar_strip dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   tws_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .cells_owed  (cells_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_item_type make_date(int unsigned m, int unsigned y,
                                               int unsigned w, int unsigned d);
      req_item_type r;
      r.month        = 4'(m);
      r.year         = 14'(y);
      r.weekday      = 3'(w);
      r.day_of_month = 5'(d);
      return r;
   endfunction

   // Mostly real dates with leap-rule years and edge days; the rest raw bits
   function automatic req_item_type random_date();
      req_item_type d;
      logic [31:0]  raw;
      raw = $urandom;
      d   = raw[25:0];
      if ($urandom_range(0, 99) < 85) begin
         d.month   = 4'($urandom_range(0, 11));
         d.weekday = 3'($urandom_range(0, 6));
         case ($urandom_range(0, 3))
            0: d.year = 14'($urandom_range(0, 163) * 100);
            1: d.year = 14'($urandom_range(0, 40) * 400);
            2: d.year = 14'($urandom_range(0, 4095) * 4);
            default: d.year = 14'($urandom_range(0, 16383));
         endcase
         case ($urandom_range(0, 2))
            0: d.day_of_month = 5'($urandom_range(1, 7));
            1: d.day_of_month = 5'($urandom_range(24, 31));
            default: d.day_of_month = 5'($urandom_range(1, 28));
         endcase
      end
      return d;
   endfunction

   // Offer one date, maybe after an idle burst, and hold it until accepted
   task automatic offer_date(input req_item_type d);
      int unsigned gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every predicted cell has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cells_owed != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_week_start(input logic [2:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Result side: random stall bursts, free stretches, one long hold-off
   initial begin
      int unsigned span;
      forever begin
         if (hold_results) begin
            rsp_stall    <= 1'b1;
            span         = LongHold;
            hold_results = 1'b0;
         end else if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            span      = $urandom_range(1, 19);
         end else begin
            rsp_stall <= 1'b0;
            span      = $urandom_range(1, 30);
         end
         repeat (span) @(posedge clock);
      end
   end

   // Date stimulus and verdict
   initial begin
      logic [2:0]  phase_start [PhaseCount];
      int unsigned p, k;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      phase_start = '{3'd6, 3'd7, 3'd0, 3'd3, 3'd1, 3'd5, 3'd2, 3'd4};
      phase_start[4] = 3'($urandom_range(0, 7));
      phase_start[6] = 3'($urandom_range(0, 7));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed dates with the week starting on Sunday
      write_week_start(3'd0);
      offer_date(make_date(0, 2024, 0, 1));     // January looks back at 31 days
      offer_date(make_date(1, 2000, 3, 28));    // leap by the 400 rule
      offer_date(make_date(1, 1900, 6, 27));    // century, not leap
      offer_date(make_date(1, 2024, 2, 29));    // leap by the 4 rule
      offer_date(make_date(1, 2023, 5, 28));    // plain February
      offer_date(make_date(2, 2024, 6, 1));     // leap February trails in
      offer_date(make_date(2, 2023, 6, 5));     // short February trails in
      offer_date(make_date(11, 9999, 0, 31));   // last month, last day
      offer_date(make_date(0, 0, 6, 14));       // year zero, no previous days
      offer_date(make_date(3, 16383, 0, 30));   // widest year, wrap after 30
      offer_date(make_date(5, 5, 5, 12));       // today right on the boundary
      offer_date(make_date(6, 2100, 3, 10));    // century non-leap, mid month
      offer_date(make_date(10, 4000, 1, 15));
      offer_date(make_date(12, 2025, 1, 20));   // month above December
      offer_date(make_date(13, 8191, 7, 0));    // bad month, weekday 7, day 0
      offer_date(make_date(15, 1234, 7, 31));   // top month code, weekday 7
      offer_date(make_date(4, 2021, 4, 0));     // day zero
      offer_date(make_date(8, 2019, 2, 31));    // day past a 30-day month
      offer_date(make_date(1, 2021, 0, 31));    // day past February
      offer_date(make_date(7, 1999, 6, 3));
      drain_results();

      // Random phases, each under its own start day
      for (p = 0; p < PhaseCount; p++) begin
         write_week_start(phase_start[p]);
         calm = (p == PhaseCount - 1);
         for (k = 0; k < PhaseItems; k++) begin
            if (p == 1 && k == 5) begin
               hold_results = 1'b1;
            end
            if (p == 2 && k == PhaseItems / 2) begin
               drain_results();
            end
            offer_date(random_date());
         end
         drain_results();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TimeLimitNs);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
sv/tws_pkg.sv
sv/tws_prep.sv
sv/tws_emit.sv
sv/three_week_calendar_strip.sv
verif/tws_checker.sv
verif/tb_top.sv
